// ===== rtl/sba_pkg.sv =====
// Shared constants for the slab block allocator: request, status and mark codes,
// configuration indexes and fixed field widths. No dependencies.
package sba_pkg;

  // Request kinds carried on in_tuser
  localparam logic [1:0] REQ_ALLOC   = 2'd0;
  localparam logic [1:0] REQ_FREE    = 2'd1;
  localparam logic [1:0] REQ_EXEC    = 2'd2;
  localparam logic [1:0] REQ_DECIM   = 2'd3;

  // Result status carried on out_tuser
  localparam logic [1:0] STAT_OK     = 2'd0;
  localparam logic [1:0] STAT_NOSPC  = 2'd1;
  localparam logic [1:0] STAT_BADFR  = 2'd2;
  localparam logic [1:0] STAT_NOEXEC = 2'd3;

  // Block marks
  localparam logic [1:0] MARK_FREE    = 2'd0;
  localparam logic [1:0] MARK_USED    = 2'd1;
  localparam logic [1:0] MARK_PENDING = 2'd2;

  // Configuration port
  localparam int CFG_W     = 11;
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_SLAB = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_SLAB = 1'd1;
  localparam logic [CFG_W-1:0] MIN_SLAB_RST = 11'd16;
  localparam logic [CFG_W-1:0] MAX_SLAB_RST = 11'd1024;
  localparam logic [CFG_W-1:0] GROW_CAP     = 11'd2047;

  // Fixed field widths
  localparam int TYPE_W  = 5;
  localparam int SIZE_W  = 32;
  localparam int ALIGN_W = 21;
  localparam int SID_W   = 3;
  localparam int OFF_W   = 20;
  localparam int IN_DATA_W  = 88;
  localparam int OUT_DATA_W = 24;

  // Fill-ratio scale used by decimate
  localparam logic [6:0] PERCENT = 7'd100;

  // Width of scan positions: covers a rounded start plus a run
  localparam int SCAN_W = 23;

endpackage

// ===== rtl/sba_div.sv =====
// Restoring divider, one quotient bit per cycle, used for the slab fill ratios.
// Standalone; no package dependencies.
module sba_div #(
  parameter int DVW = 18,
  parameter int DSW = 11
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic [DVW-1:0] dividend,
  input  logic [DSW-1:0] divisor,
  output logic           done,
  output logic [DVW-1:0] quotient
);

  localparam int CW = $clog2(DVW + 1);

  logic [CW-1:0]  cnt_r;
  logic [DVW-1:0] q_r;
  logic [DSW-1:0] rem_r;
  logic [DSW-1:0] d_r;
  logic           done_r;
  logic [DSW:0]   trial;
  logic           fits;

  // Shift in the next dividend bit and try the subtract
  assign trial = {rem_r, q_r[DVW-1]};
  assign fits  = trial >= {1'b0, d_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        cnt_r <= CW'(DVW);
        q_r   <= dividend;
        rem_r <= '0;
        d_r   <= divisor;
      end else if (cnt_r != '0) begin
        cnt_r <= cnt_r - 1'b1;
        if (fits) begin
          rem_r <= DSW'(trial - {1'b0, d_r});
          q_r   <= {q_r[DVW-2:0], 1'b1};
        end else begin
          rem_r <= DSW'(trial);
          q_r   <= {q_r[DVW-2:0], 1'b0};
        end
        if (cnt_r == CW'(1)) begin
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done     = done_r;
  assign quotient = q_r;

endmodule

// ===== rtl/slab_block_allocator_core.sv =====
// Slab block allocator. One request word in, one result word out. Allocate reads
// blocks from the block memory, places the run block by block and visits slabs in
// turn; a miss that opens a new slab doubles its size as needed and sweeps the
// blocks of the new slab clear (up to BLOCKS_PER_SLAB). Free checks the run start;
// execute-free also clears the run block by block. Decimate walks the slots, with
// two divisions for every slab in use and a walk of runs where a hint is rebuilt.
// No clearing pass follows reset: a slab's blocks are cleared when it is opened. A
// new word is accepted while the previous result is still held.
module slab_block_allocator_core #(
  parameter int NUM_SLABS       = 8,
  parameter int BLOCKS_PER_SLAB = 1024,
  parameter int GRAIN_SHIFT     = 10
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // Configuration writes
  input  logic                            cfg_we,
  input  logic [sba_pkg::CFG_IDX_W-1:0]   cfg_addr,
  input  logic [sba_pkg::CFG_W-1:0]       cfg_wdata,
  // Request stream
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // mem_type[4:0], size_bytes[36:5], align_bytes[57:37], slab_id[60:58],
  // offset_bytes[80:61], zero pad[87:81]
  input  logic [sba_pkg::IN_DATA_W-1:0]   in_tdata,
  // req_type[1:0]
  input  logic [1:0]                      in_tuser,
  // Result stream
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // out_slab[2:0], out_offset[22:3], zero pad[23]
  output logic [sba_pkg::OUT_DATA_W-1:0]  out_tdata,
  // status[1:0]
  output logic [1:0]                      out_tuser
);
  import sba_pkg::*;

  localparam int SW    = (NUM_SLABS > 1) ? $clog2(NUM_SLABS) : 1;
  localparam int BW    = $clog2(BLOCKS_PER_SLAB + 1);
  localparam int IW    = $clog2(BLOCKS_PER_SLAB);
  localparam int SZW   = (BW + 1 > CFG_W) ? BW + 1 : CFG_W;
  localparam int DEPTH = NUM_SLABS * BLOCKS_PER_SLAB;
  localparam int AW    = $clog2(DEPTH);
  localparam int MW    = BW + 2;
  localparam int DVW   = BW + 7;
  localparam int XW    = SCAN_W;

  // Sequencer states
  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_SLAB  = 5'd1;
  localparam logic [4:0] S_ROUND = 5'd2;
  localparam logic [4:0] S_RD    = 5'd3;
  localparam logic [4:0] S_EV    = 5'd4;
  localparam logic [4:0] S_PLACE = 5'd5;
  localparam logic [4:0] S_GROW  = 5'd6;
  localparam logic [4:0] S_SIZE  = 5'd7;
  localparam logic [4:0] S_CLEAR = 5'd8;
  localparam logic [4:0] S_FCHK  = 5'd9;
  localparam logic [4:0] S_FEV   = 5'd10;
  localparam logic [4:0] S_XCLR  = 5'd11;
  localparam logic [4:0] S_DSLAB = 5'd12;
  localparam logic [4:0] S_DDIV1 = 5'd13;
  localparam logic [4:0] S_DDIV2 = 5'd14;
  localparam logic [4:0] S_DRD   = 5'd15;
  localparam logic [4:0] S_DEV   = 5'd16;
  localparam logic [4:0] S_DONE  = 5'd17;

  // Control and request registers
  logic [4:0]        state_r;
  logic [1:0]        req_r;
  logic [TYPE_W-1:0] mtype_r;
  logic [SW-1:0]     s_r;
  logic [SW-1:0]     scnt_r;
  logic [BW-1:0]     blocks_r;
  logic [XW-1:0]     am_r;
  logic [XW-1:0]     start_r;
  logic [XW-1:0]     rs_r;
  logic [SZW-1:0]    cnt_r;
  logic [SZW-1:0]    sz_r;
  logic [BW-1:0]     len_r;
  logic              sid_ok_r;
  logic              kept_r;
  logic [6:0]        usage_r;

  // Per-slab state
  logic              active_r [NUM_SLABS];
  logic [TYPE_W-1:0] type_r   [NUM_SLABS];
  logic [BW-1:0]     size_r   [NUM_SLABS];
  logic [IW-1:0]     hint_r   [NUM_SLABS];
  logic [BW-1:0]     used_r   [NUM_SLABS];
  logic [SW-1:0]     last_r;
  logic [CFG_W-1:0]  grow_r;
  logic [CFG_W-1:0]  max_r;

  // Result registers
  logic [1:0]        res_status_r;
  logic [SW-1:0]     res_slab_r;
  logic [XW-1:0]     res_blk_r;
  logic              out_valid_r;
  logic [1:0]        out_status_r;
  logic [2:0]        out_slab_r;
  logic [OFF_W-1:0]  out_off_r;

  // Block memory: {run length, mark} per block
  logic [MW-1:0]     mem [0:DEPTH-1];
  logic [MW-1:0]     rdata_r;
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [MW-1:0]     mem_wdata;
  logic [AW-1:0]     mem_raddr;

  // Input fields
  logic [TYPE_W-1:0]  f_type;
  logic [SIZE_W-1:0]  f_size;
  logic [ALIGN_W-1:0] f_align;
  logic [SID_W-1:0]   f_sid;
  logic [OFF_W-1:0]   f_off;

  // Derived values
  logic [SIZE_W:0]    blk_raw;
  logic [SIZE_W:0]    blk_fix;
  logic               oversize;
  logic [ALIGN_W-1:0] a_blk;
  logic [ALIGN_W-1:0] a_smear;
  logic [XW-1:0]      am_new;
  logic [AW-1:0]      base;
  logic [BW-1:0]      cur_size;
  logic [XW-1:0]      rs_new;
  logic               round_fail;
  logic [BW-1:0]      rd_rl;
  logic [1:0]         rd_mark;
  logic [XW-1:0]      ev_next;
  logic               xmore;
  logic               any_active;
  logic [SW-1:0]      slot;
  logic               slot_ok;
  logic [CFG_W:0]     grow_dbl;
  logic [CFG_W-1:0]   grow_new;
  logic [SW-1:0]      s_inc;
  logic [IW-1:0]      place_hint;
  logic [IW-1:0]      clear_hint;

  // Divider hookup
  logic               div_start;
  logic [DVW-1:0]     div_dividend;
  logic               div_done;
  logic [DVW-1:0]     div_q;

  assign f_type  = in_tdata[4:0];
  assign f_size  = in_tdata[36:5];
  assign f_align = in_tdata[57:37];
  assign f_sid   = in_tdata[60:58];
  assign f_off   = in_tdata[80:61];

  // Round the size up to blocks; zero size counts as one block
  assign blk_raw  = ({1'b0, f_size} + (SIZE_W+1)'((1 << GRAIN_SHIFT) - 1)) >> GRAIN_SHIFT;
  assign blk_fix  = (blk_raw == '0) ? (SIZE_W+1)'(1) : blk_raw;
  assign oversize = blk_fix > (SIZE_W+1)'(BLOCKS_PER_SLAB);

  // Alignment mask: highest power of two within the block alignment, minus one
  assign a_blk = f_align >> GRAIN_SHIFT;
  always_comb begin
    a_smear = a_blk;
    for (int k = ALIGN_W - 2; k >= 0; k--) begin
      a_smear[k] = a_smear[k+1] | a_blk[k];
    end
  end
  assign am_new = (f_align > ALIGN_W'(1 << GRAIN_SHIFT)) ? XW'(a_smear >> 1) : '0;

  assign base     = AW'(s_r * BLOCKS_PER_SLAB);
  assign cur_size = size_r[s_r];

  // Scan step: align the start and test that the run fits in the slab
  assign rs_new     = (start_r + am_r) & ~am_r;
  assign round_fail = (start_r >= XW'(cur_size)) ||
                      ((rs_new + XW'(blocks_r)) > XW'(cur_size));

  assign rd_rl   = rdata_r[MW-1:2];
  assign rd_mark = rdata_r[1:0];
  assign ev_next = rs_r + XW'(cnt_r) + ((rd_rl != '0) ? XW'(rd_rl) : XW'(1));

  assign xmore = (XW'(cnt_r) < XW'(len_r)) &&
                 ((start_r + XW'(cnt_r)) < XW'(cur_size));

  // Lowest inactive slot
  always_comb begin
    any_active = 1'b0;
    slot_ok    = 1'b0;
    slot       = '0;
    for (int k = 0; k < NUM_SLABS; k++) begin
      if (active_r[k]) begin
        any_active = 1'b1;
      end else if (!slot_ok) begin
        slot_ok = 1'b1;
        slot    = SW'(k);
      end
    end
  end

  // Growth of the new-slab size, saturating
  assign grow_dbl = {grow_r, 1'b0};
  always_comb begin
    grow_new = grow_r;
    if (any_active && grow_r < max_r) begin
      grow_new = (grow_dbl > (CFG_W+1)'(GROW_CAP)) ? GROW_CAP : grow_dbl[CFG_W-1:0];
    end
  end

  assign s_inc      = (s_r == SW'(NUM_SLABS - 1)) ? '0 : SW'(s_r + 1'b1);
  assign place_hint = ((rs_r + XW'(blocks_r)) >= XW'(cur_size)) ? '0
                    : IW'(rs_r + XW'(blocks_r));
  assign clear_hint = (SZW'(blocks_r) >= sz_r) ? '0 : IW'(blocks_r);

  // Memory access selection
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = base;
    mem_wdata = '0;
    mem_raddr = base + AW'(start_r);
    div_start    = 1'b0;
    div_dividend = DVW'(used_r[s_r]) * DVW'(PERCENT);
    unique case (state_r)
      S_RD: begin
        mem_raddr = base + AW'(rs_r + XW'(cnt_r));
      end
      S_PLACE: begin
        mem_we    = 1'b1;
        mem_waddr = base + AW'(rs_r + XW'(cnt_r));
        mem_wdata = {((cnt_r == '0) ? blocks_r : BW'(0)), MARK_USED};
      end
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = base + AW'(cnt_r);
        mem_wdata = (cnt_r < SZW'(blocks_r))
                  ? {((cnt_r == '0) ? blocks_r : BW'(0)), MARK_USED} : MW'(0);
      end
      S_FEV: begin
        mem_waddr = base + AW'(start_r);
        mem_wdata = {rd_rl, MARK_PENDING};
        mem_we    = (req_r == REQ_FREE) && (rd_rl != '0) && (rd_mark == MARK_USED);
      end
      S_XCLR: begin
        mem_we    = xmore;
        mem_waddr = base + AW'(start_r + XW'(cnt_r));
        mem_wdata = '0;
      end
      S_DSLAB: begin
        div_start = active_r[s_r] && (used_r[s_r] != '0);
      end
      S_DDIV1: begin
        div_start    = div_done;
        div_dividend = DVW'(hint_r[s_r]) * DVW'(PERCENT);
      end
      default: begin
      end
    endcase
  end

  // Block memory, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_r <= mem[mem_raddr];
  end

  sba_div #(
    .DVW (DVW),
    .DSW (BW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (cur_size),
    .done     (div_done),
    .quotient (div_q)
  );

  assign in_tready = (state_r == S_IDLE);

  // Request sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      last_r      <= '0;
      grow_r      <= MIN_SLAB_RST;
      max_r       <= MAX_SLAB_RST;
      out_valid_r <= 1'b0;
      for (int k = 0; k < NUM_SLABS; k++) begin
        active_r[k] <= 1'b0;
      end
    end else begin
      // Drop the held result once taken, unless a new one replaces it
      if (out_valid_r && out_tready && state_r != S_DONE) begin
        out_valid_r <= 1'b0;
      end
      // The user must make configuration writes arrive only while idle; the block does not enforce it
      if (cfg_we) begin
        if (cfg_addr == CFG_MIN_SLAB) begin
          grow_r <= cfg_wdata;
        end else begin
          max_r <= cfg_wdata;
        end
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            req_r        <= in_tuser;
            mtype_r      <= f_type;
            blocks_r     <= BW'(blk_fix);
            am_r         <= am_new;
            sid_ok_r     <= (32'(f_sid) < NUM_SLABS);
            start_r      <= XW'(f_off >> GRAIN_SHIFT);
            kept_r       <= 1'b0;
            scnt_r       <= '0;
            res_status_r <= STAT_OK;
            res_slab_r   <= '0;
            res_blk_r    <= '0;
            unique case (in_tuser)
              REQ_ALLOC: begin
                s_r <= last_r;
                if (oversize) begin
                  res_status_r <= STAT_NOSPC;
                  state_r      <= S_DONE;
                end else begin
                  state_r <= S_SLAB;
                end
              end
              REQ_FREE, REQ_EXEC: begin
                s_r     <= SW'(f_sid);
                state_r <= S_FCHK;
              end
              default: begin
                s_r     <= SW'(NUM_SLABS - 1);
                state_r <= S_DSLAB;
              end
            endcase
          end
        end

        // Visit slabs in rotation from the last one that served
        S_SLAB: begin
          if (active_r[s_r] && type_r[s_r] == mtype_r) begin
            start_r <= XW'(hint_r[s_r]);
            state_r <= S_ROUND;
          end else if (scnt_r == SW'(NUM_SLABS - 1)) begin
            state_r <= S_GROW;
          end else begin
            scnt_r  <= scnt_r + 1'b1;
            s_r     <= s_inc;
          end
        end

        S_ROUND: begin
          if (round_fail) begin
            if (scnt_r == SW'(NUM_SLABS - 1)) begin
              state_r <= S_GROW;
            end else begin
              scnt_r  <= scnt_r + 1'b1;
              s_r     <= s_inc;
              state_r <= S_SLAB;
            end
          end else begin
            rs_r    <= rs_new;
            cnt_r   <= '0;
            state_r <= S_RD;
          end
        end

        S_RD: begin
          state_r <= S_EV;
        end

        // Check one block; on an occupied block skip its run, or one block if it holds no run length
        S_EV: begin
          if (rd_mark != MARK_FREE) begin
            start_r <= ev_next;
            state_r <= S_ROUND;
          end else if (cnt_r == SZW'(blocks_r - 1'b1)) begin
            cnt_r   <= '0;
            state_r <= S_PLACE;
          end else begin
            cnt_r   <= cnt_r + 1'b1;
            state_r <= S_RD;
          end
        end

        S_PLACE: begin
          if (cnt_r == SZW'(blocks_r - 1'b1)) begin
            hint_r[s_r] <= place_hint;
            used_r[s_r] <= used_r[s_r] + blocks_r;
            last_r      <= s_r;
            res_slab_r  <= s_r;
            res_blk_r   <= rs_r;
            state_r     <= S_DONE;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end

        // Open a new slab
        S_GROW: begin
          grow_r  <= grow_new;
          sz_r    <= (grow_new == '0) ? SZW'(1) : SZW'(grow_new);
          state_r <= S_SIZE;
        end

        S_SIZE: begin
          if (sz_r < SZW'(blocks_r)) begin
            sz_r <= {sz_r[SZW-2:0], 1'b0};
          end else if (sz_r > SZW'(BLOCKS_PER_SLAB) || !slot_ok) begin
            res_status_r <= STAT_NOSPC;
            state_r      <= S_DONE;
          end else begin
            s_r     <= slot;
            cnt_r   <= '0;
            state_r <= S_CLEAR;
          end
        end

        S_CLEAR: begin
          if (cnt_r == sz_r - 1'b1) begin
            active_r[s_r] <= 1'b1;
            type_r[s_r]   <= mtype_r;
            size_r[s_r]   <= BW'(sz_r);
            hint_r[s_r]   <= clear_hint;
            used_r[s_r]   <= blocks_r;
            last_r        <= s_r;
            res_slab_r    <= s_r;
            res_blk_r     <= '0;
            state_r       <= S_DONE;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end

        // Locate the run start for free and execute-free
        S_FCHK: begin
          if (sid_ok_r && active_r[s_r] && start_r < XW'(cur_size)) begin
            state_r <= S_FEV;
          end else begin
            res_status_r <= (req_r == REQ_FREE) ? STAT_BADFR : STAT_NOEXEC;
            state_r      <= S_DONE;
          end
        end

        S_FEV: begin
          if (req_r == REQ_FREE) begin
            if (!(rd_rl != '0 && rd_mark == MARK_USED)) begin
              res_status_r <= STAT_BADFR;
            end
            state_r <= S_DONE;
          end else if (rd_rl == '0) begin
            res_status_r <= STAT_NOEXEC;
            state_r      <= S_DONE;
          end else begin
            len_r   <= rd_rl;
            cnt_r   <= '0;
            state_r <= S_XCLR;
          end
        end

        S_XCLR: begin
          if (xmore) begin
            cnt_r <= cnt_r + 1'b1;
          end else begin
            used_r[s_r] <= (used_r[s_r] >= len_r) ? BW'(used_r[s_r] - len_r) : '0;
            if (XW'(hint_r[s_r]) > start_r) begin
              hint_r[s_r] <= IW'(start_r);
            end
            state_r <= S_DONE;
          end
        end

        // Decimate: walk slots from the top, keep one empty slab
        S_DSLAB: begin
          if (active_r[s_r] && used_r[s_r] != '0) begin
            state_r <= S_DDIV1;
          end else begin
            if (active_r[s_r]) begin
              if (!kept_r) begin
                kept_r <= 1'b1;
              end else begin
                active_r[s_r] <= 1'b0;
              end
            end
            if (s_r == '0) begin
              state_r <= S_DONE;
            end else begin
              s_r <= s_r - 1'b1;
            end
          end
        end

        S_DDIV1: begin
          if (div_done) begin
            usage_r <= (div_q > DVW'(PERCENT)) ? PERCENT : 7'(div_q);
            state_r <= S_DDIV2;
          end
        end

        S_DDIV2: begin
          if (div_done) begin
            if (div_q >= DVW'(PERCENT - usage_r)) begin
              start_r <= '0;
              state_r <= S_DRD;
            end else if (s_r == '0) begin
              state_r <= S_DONE;
            end else begin
              s_r     <= s_r - 1'b1;
              state_r <= S_DSLAB;
            end
          end
        end

        // Rebuild the hint by walking runs from block zero
        S_DRD: begin
          if (start_r >= XW'(cur_size)) begin
            hint_r[s_r] <= '0;
            if (s_r == '0) begin
              state_r <= S_DONE;
            end else begin
              s_r     <= s_r - 1'b1;
              state_r <= S_DSLAB;
            end
          end else begin
            state_r <= S_DEV;
          end
        end

        S_DEV: begin
          if (rd_rl != '0) begin
            start_r <= start_r + XW'(rd_rl);
            state_r <= S_DRD;
          end else begin
            hint_r[s_r] <= IW'(start_r);
            if (s_r == '0) begin
              state_r <= S_DONE;
            end else begin
              s_r     <= s_r - 1'b1;
              state_r <= S_DSLAB;
            end
          end
        end

        // Hand the result to the output register
        S_DONE: begin
          if (!out_valid_r || out_tready) begin
            out_valid_r  <= 1'b1;
            out_status_r <= res_status_r;
            out_slab_r   <= 3'(res_slab_r);
            out_off_r    <= OFF_W'((XW+16)'(res_blk_r) << GRAIN_SHIFT);
            state_r      <= S_IDLE;
          end
        end

        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_off_r, out_slab_r};
  assign out_tuser  = out_status_r;

endmodule

// ===== verif/slab_block_allocator_core_tb.sv =====
// Testbench for slab_block_allocator_core: drives request words, predicts each
// result with a local allocator model and checks every result word. Needs sba_pkg.
`timescale 1ns / 100ps

module slab_block_allocator_core_tb;
  import sba_pkg::*;

  localparam int NSLAB    = 8;
  localparam int SLAB_BLK = 1024;
  localparam int GRAIN    = 10;
  localparam int IDLE_LIMIT = 200000;

  typedef struct packed {
    logic [1:0]  status;
    logic [2:0]  slab;
    logic [19:0] offset;
  } alloc_result_t;

  typedef struct packed {
    logic [2:0]  slab;
    logic [19:0] offset;
  } run_ref_t;

  // Allocator model plus the queue of results it has predicted
  class alloc_scoreboard;
    bit [1:0]    mark[NSLAB*SLAB_BLK];
    int unsigned rlen[NSLAB*SLAB_BLK];
    bit          active[NSLAB];
    int unsigned stype[NSLAB];
    int unsigned ssize[NSLAB];
    int unsigned hint[NSLAB];
    int unsigned used[NSLAB];
    int unsigned last_s;
    int unsigned grow;
    int unsigned min_blk;
    int unsigned max_blk;
    alloc_result_t due_q[$];
    int errors;

    function new();
      for (int i = 0; i < NSLAB*SLAB_BLK; i++) begin
        mark[i] = MARK_FREE;
        rlen[i] = 0;
      end
      for (int i = 0; i < NSLAB; i++) begin
        active[i] = 0;
        stype[i] = 0;
        ssize[i] = 0;
        hint[i] = 0;
        used[i] = 0;
      end
      last_s = 0;
      min_blk = MIN_SLAB_RST;
      max_blk = MAX_SLAB_RST;
      grow = min_blk;
      errors = 0;
    endfunction

    function void set_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
      if (idx == CFG_MIN_SLAB) begin
        min_blk = val;
        grow = val;
      end else begin
        max_blk = val;
      end
    endfunction

    // Place a run at start, or advance start past the obstacle
    function bit place(int unsigned s, inout int unsigned start, input int unsigned blocks);
      int unsigned base;
      int unsigned b;
      base = s * SLAB_BLK;
      if (start + blocks > ssize[s]) begin
        start = ssize[s];
        return 0;
      end
      for (int unsigned i = 0; i < blocks; i++) begin
        b = base + start + i;
        if (mark[b] != MARK_FREE) begin
          start = start + i + (rlen[b] != 0 ? rlen[b] : 1);
          return 0;
        end
      end
      for (int unsigned i = 0; i < blocks; i++) mark[base + start + i] = MARK_USED;
      rlen[base + start] = blocks;
      hint[s] = (start + blocks >= ssize[s]) ? 0 : start + blocks;
      used[s] += blocks;
      last_s = s;
      return 1;
    endfunction

    function alloc_result_t allocate(int unsigned mtype, logic [31:0] size_b,
                                     logic [20:0] align_b);
      alloc_result_t r;
      longint unsigned blk64;
      int unsigned blocks, al, a, s, start, sz;
      bit any;
      int slot;
      r = '0;
      any = 0;
      slot = -1;
      al = 1;
      blk64 = (longint'(size_b) + (1 << GRAIN) - 1) >> GRAIN;
      if (blk64 == 0) blk64 = 1;
      if (align_b > (1 << GRAIN)) begin
        a = align_b >> GRAIN;
        while ((al << 1) <= a) al = al << 1;
      end
      if (blk64 > SLAB_BLK) begin
        r.status = STAT_NOSPC;
        return r;
      end
      blocks = 32'(blk64);
      // Visit matching slabs in rotation from the last one that served
      for (int unsigned i = 0; i < NSLAB; i++) begin
        s = (last_s + i) % NSLAB;
        if (!active[s] || stype[s] != mtype) continue;
        start = hint[s];
        while (start < ssize[s]) begin
          start = (start + al - 1) & ~(al - 1);
          if (place(s, start, blocks)) begin
            r.status = STAT_OK;
            r.slab = 3'(s);
            r.offset = 20'(start << GRAIN);
            return r;
          end
        end
      end
      // Open a new slab
      for (int i = 0; i < NSLAB; i++) begin
        if (active[i]) any = 1;
        else if (slot < 0) slot = i;
      end
      if (any && grow < max_blk) begin
        grow = grow << 1;
        if (grow > GROW_CAP) grow = GROW_CAP;
      end
      sz = (grow == 0) ? 1 : grow;
      while (sz < blocks) sz = sz << 1;
      if (sz > SLAB_BLK || slot < 0) begin
        r.status = STAT_NOSPC;
        return r;
      end
      s = slot;
      for (int unsigned i = 0; i < SLAB_BLK; i++) begin
        mark[s*SLAB_BLK + i] = MARK_FREE;
        rlen[s*SLAB_BLK + i] = 0;
      end
      active[s] = 1;
      stype[s] = mtype;
      ssize[s] = sz;
      hint[s] = 0;
      used[s] = 0;
      start = 0;
      if (!place(s, start, blocks)) begin
        r.status = STAT_NOSPC;
        return r;
      end
      r.status = STAT_OK;
      r.slab = 3'(s);
      return r;
    endfunction

    function int find_run(int unsigned s, logic [19:0] off);
      int unsigned start;
      start = off >> GRAIN;
      if (s >= NSLAB || !active[s] || start >= ssize[s]) return -1;
      if (rlen[s*SLAB_BLK + start] == 0) return -1;
      return s*SLAB_BLK + start;
    endfunction

    function void decimate();
      bit kept;
      int unsigned s, sz, base, usage, nfp, nf;
      kept = 0;
      for (int k = NSLAB; k > 0; k--) begin
        s = k - 1;
        if (!active[s]) continue;
        if (used[s] != 0) begin
          sz = ssize[s];
          base = s * SLAB_BLK;
          usage = PERCENT * used[s] / sz;
          nfp = PERCENT * hint[s] / sz;
          if (usage > PERCENT) usage = PERCENT;
          if (nfp >= PERCENT - usage) begin
            nf = 0;
            while (nf < sz && rlen[base + nf] != 0) nf += rlen[base + nf];
            hint[s] = (nf >= sz) ? 0 : nf;
          end
          continue;
        end
        if (!kept) begin
          kept = 1;
          continue;
        end
        active[s] = 0;
      end
    endfunction

    // Apply one accepted request word and queue its result
    function alloc_result_t note_request(logic [1:0] req, logic [4:0] mtype,
        logic [31:0] size_b, logic [20:0] align_b, logic [2:0] sid, logic [19:0] off);
      alloc_result_t r;
      int b;
      int unsigned len, start;
      r = '0;
      case (req)
        REQ_ALLOC: r = allocate(mtype, size_b, align_b);
        REQ_FREE: begin
          b = find_run(sid, off);
          if (b < 0 || mark[b] != MARK_USED) r.status = STAT_BADFR;
          else mark[b] = MARK_PENDING;
        end
        REQ_EXEC: begin
          b = find_run(sid, off);
          if (b < 0) begin
            r.status = STAT_NOEXEC;
          end else begin
            len = rlen[b];
            start = b - sid * SLAB_BLK;
            for (int unsigned i = 0; i < len && start + i < ssize[sid]; i++)
              mark[b + i] = MARK_FREE;
            rlen[b] = 0;
            used[sid] = (used[sid] >= len) ? used[sid] - len : 0;
            if (hint[sid] > start) hint[sid] = start;
          end
        end
        default: decimate();
      endcase
      due_q = {due_q, r};
      return r;
    endfunction

    task report(string what);
      $display("MISMATCH at %0t: %s", $realtime, what);
      errors++;
    endtask

    task check_result(logic [1:0] st, logic [2:0] slab, logic [19:0] off);
      alloc_result_t e;
      if (due_q.size() == 0) begin
        report($sformatf("unexpected result status=%0d slab=%0d offset=%0h", st, slab, off));
        return;
      end
      e = due_q.pop_front();
      if (st !== e.status)
        report($sformatf("status %0d, predicted %0d", st, e.status));
      if (slab !== e.slab)
        report($sformatf("slab %0d, predicted %0d", slab, e.slab));
      if (off !== e.offset)
        report($sformatf("offset %0h, predicted %0h", off, e.offset));
    endtask
  endclass

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_addr;
  logic [CFG_W-1:0] cfg_wdata;
  logic in_tvalid;
  logic in_tready;
  logic [IN_DATA_W-1:0] in_tdata;
  logic [1:0] in_tuser;
  logic out_tvalid;
  logic out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [1:0] out_tuser;

  alloc_scoreboard sb;
  run_ref_t live_q[$];
  run_ref_t pending_q[$];
  bit quiet;
  int stall_left = 0;
  int idle_cycles = 0;

  slab_block_allocator_core i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Stall the result side in random bursts
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else if (!quiet && rst_n && $urandom_range(0, 9) == 0) begin
      stall_left = $urandom_range(0, 17);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Check result words mid-cycle, where every signal is settled
  always @(negedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      sb.check_result(out_tuser, out_tdata[2:0], out_tdata[22:3]);
  end

  // Watchdog: end the run when no word moves for too long
  always @(negedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || !rst_n) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("slab_block_allocator_core verification failed");
        $finish;
      end
    end
  end

  task send_word(logic [1:0] req, logic [4:0] mtype, logic [31:0] size_b,
                 logic [20:0] align_b, logic [2:0] sid, logic [19:0] off);
    alloc_result_t r;
    run_ref_t nr;
    bit rdy;
    int gap;
    // Random gap before the word, skipped near the end
    if (!quiet && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 18);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= req;
    in_tdata <= {7'b0, off, sid, align_b, size_b, mtype};
    do begin
      @(negedge clk);
      rdy = in_tready;
      @(posedge clk);
    end while (!rdy);
    r = sb.note_request(req, mtype, size_b, align_b, sid, off);
    if (req == REQ_ALLOC && r.status == STAT_OK) begin
      nr.slab = r.slab;
      nr.offset = r.offset;
      live_q = {live_q, nr};
    end
  endtask

  task drain();
    in_tvalid <= 1'b0;
    while (sb.due_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_cfg(idx, val);
    @(posedge clk);
  endtask

  function logic [20:0] pick_align();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 21'd1;
    if (r < 95) return 21'd1 << $urandom_range(0, 20);
    return 21'($urandom);
  endfunction

  function logic [31:0] pick_size();
    int r;
    r = $urandom_range(0, 99);
    if (r < 85) return $urandom_range(1, 8 * 1024);
    if (r < 95) return $urandom_range(1, 1024 * 1024);
    return $urandom;
  endfunction

  task random_word();
    int r;
    int k;
    run_ref_t x;
    r = $urandom_range(0, 99);
    if (r < 45) begin
      send_word(REQ_ALLOC,
                5'(($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 2)),
                pick_size(), pick_align(), 3'($urandom), 20'($urandom));
    end else if (r < 62 && live_q.size() != 0) begin
      k = $urandom_range(0, live_q.size() - 1);
      x = live_q[k];
      live_q.delete(k);
      pending_q = {pending_q, x};
      send_word(REQ_FREE, 5'($urandom), $urandom, 21'($urandom), x.slab, x.offset);
    end else if (r < 80 && (pending_q.size() != 0 || live_q.size() != 0)) begin
      if (pending_q.size() != 0 && $urandom_range(0, 3) != 0) begin
        k = $urandom_range(0, pending_q.size() - 1);
        x = pending_q[k];
        pending_q.delete(k);
      end else if (live_q.size() != 0) begin
        k = $urandom_range(0, live_q.size() - 1);
        x = live_q[k];
        live_q.delete(k);
      end else begin
        x = pending_q.pop_front();
      end
      send_word(REQ_EXEC, 5'($urandom), $urandom, 21'($urandom), x.slab, x.offset);
    end else if (r < 86) begin
      send_word(REQ_DECIM, 5'($urandom), $urandom, 21'($urandom), 3'($urandom),
                20'($urandom));
    end else begin
      // Noise: any request with random fields
      send_word(2'($urandom), 5'($urandom), pick_size(), 21'($urandom), 3'($urandom),
                20'($urandom));
    end
  endtask

  initial begin
    logic [CFG_W-1:0] phase_min[6];
    logic [CFG_W-1:0] phase_max[6];
    sb = new();
    quiet = 0;
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_addr <= '0;
    cfg_wdata <= '0;
    in_tvalid <= 1'b0;
    in_tdata <= '0;
    in_tuser <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: size, alignment, free, execute-free and decimate corner cases at reset settings
    send_word(REQ_ALLOC, 5'd0, 32'd0, 21'd0, 3'd0, 20'd0);
    send_word(REQ_ALLOC, 5'd0, 32'd1, 21'd1, 3'd0, 20'd0);
    send_word(REQ_ALLOC, 5'd0, 32'd1500, 21'd1024, 3'd0, 20'd0);
    send_word(REQ_ALLOC, 5'd0, 32'd1024, 21'd2048, 3'd0, 20'd0);
    send_word(REQ_ALLOC, 5'd0, 32'd2048, 21'd3000, 3'd0, 20'd0);
    send_word(REQ_ALLOC, 5'd0, 32'd100, 21'h1FFFFF, 3'd0, 20'd0);
    send_word(REQ_ALLOC, 5'd31, 32'd1024 * 1024, 21'd1048576, 3'd0, 20'd0);
    send_word(REQ_ALLOC, 5'd31, 32'd1024 * 1024 + 1, 21'd1, 3'd0, 20'd0);
    send_word(REQ_ALLOC, 5'd3, 32'hFFFF_FFFF, 21'd1, 3'd0, 20'd0);
    send_word(REQ_FREE, 5'd0, 32'd0, 21'd0, 3'd0, 20'd0);
    send_word(REQ_FREE, 5'd0, 32'd0, 21'd0, 3'd0, 20'd0);
    send_word(REQ_EXEC, 5'd0, 32'd0, 21'd0, 3'd0, 20'd0);
    send_word(REQ_EXEC, 5'd0, 32'd0, 21'd0, 3'd0, 20'd0);
    send_word(REQ_EXEC, 5'd0, 32'd0, 21'd0, 3'd0, 20'd1024);
    send_word(REQ_FREE, 5'd0, 32'd0, 21'd0, 3'd7, 20'd0);
    send_word(REQ_EXEC, 5'd0, 32'd0, 21'd0, 3'd7, 20'hFFFFF);
    send_word(REQ_FREE, 5'd0, 32'd0, 21'd0, 3'd0, 20'hFFFFF);
    send_word(REQ_FREE, 5'd0, 32'd0, 21'd0, 3'd0, 20'd1500);
    send_word(REQ_DECIM, 5'd0, 32'd0, 21'd0, 3'd0, 20'd0);
    send_word(REQ_ALLOC, 5'd0, 32'd5000, 21'd1, 3'd0, 20'd0);
    send_word(REQ_DECIM, 5'd0, 32'd0, 21'd0, 3'd0, 20'd0);
    live_q.delete();
    pending_q.delete();

    // Random phases across register settings, extremes included
    phase_min = '{11'd16, 11'd1, 11'd1024, 11'd1, 11'd4, 11'd16};
    phase_max = '{11'd1024, 11'd1, 11'd1024, 11'd1024, 11'd64, 11'd1024};
    for (int p = 0; p < 6; p++) begin
      drain();
      write_cfg(CFG_MAX_SLAB, phase_max[p]);
      write_cfg(CFG_MIN_SLAB, phase_min[p]);
      for (int n = 0; n < 172; n++) begin
        if (p == 5 && n >= 120) quiet = 1;
        random_word();
      end
    end

    // Let the last results arrive, then settle
    in_tvalid <= 1'b0;
    while (sb.due_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (sb.errors == 0) begin
      $display("slab_block_allocator_core verification clean");
    end else begin
      $display("slab_block_allocator_core verification failed");
    end
    $finish;
  end

endmodule
